// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled at the rising clock edge and ignored while reset is low.
`define UPMEP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Property sampled at the rising clock edge, also checked during reset.
`define UPMEP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/upmep_pkg.sv -----
package upmep_pkg;

    // Field widths of the ports.
    localparam int VAL_W    = 8;
    localparam int KIND_W   = 4;
    localparam int CHAN_W   = 4;
    localparam int WIDE_W   = 15;
    localparam int ENABLE_W = 13;

    localparam int SYSEX_BYTES_DEF = 32;
    localparam logic [ENABLE_W-1:0] ENABLE_RESET = '1;

    // Result kinds.
    localparam logic [KIND_W-1:0] K_NOTE_ON    = 4'd0;
    localparam logic [KIND_W-1:0] K_NOTE_OFF   = 4'd1;
    localparam logic [KIND_W-1:0] K_CONTROL    = 4'd2;
    localparam logic [KIND_W-1:0] K_PROGRAM    = 4'd3;
    localparam logic [KIND_W-1:0] K_BEND       = 4'd4;
    localparam logic [KIND_W-1:0] K_CHAN_PRESS = 4'd5;
    localparam logic [KIND_W-1:0] K_POLY       = 4'd6;
    localparam logic [KIND_W-1:0] K_TIMECODE   = 4'd7;
    localparam logic [KIND_W-1:0] K_SONGPOS    = 4'd8;
    localparam logic [KIND_W-1:0] K_SONGSEL    = 4'd9;
    localparam logic [KIND_W-1:0] K_TUNE       = 4'd10;
    localparam logic [KIND_W-1:0] K_REALTIME   = 4'd11;
    localparam logic [KIND_W-1:0] K_SYSEX      = 4'd12;

    // MIDI byte codes.
    localparam logic [VAL_W-1:0] BYTE_RT_MIN   = 8'hF8;
    localparam logic [VAL_W-1:0] BYTE_SX_START = 8'hF0;
    localparam logic [VAL_W-1:0] BYTE_SX_END   = 8'hF7;
    localparam logic [VAL_W-1:0] BYTE_MTC      = 8'hF1;
    localparam logic [VAL_W-1:0] BYTE_SPP      = 8'hF2;
    localparam logic [VAL_W-1:0] BYTE_SSEL     = 8'hF3;
    localparam logic [VAL_W-1:0] BYTE_TUNE     = 8'hF6;

    // Status high nibbles.
    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_POLY     = 4'hA;
    localparam logic [3:0] ST_CONTROL  = 4'hB;
    localparam logic [3:0] ST_PROGRAM  = 4'hC;
    localparam logic [3:0] ST_CHPRESS  = 4'hD;
    localparam logic [3:0] ST_BEND     = 4'hE;
    localparam logic [3:0] ST_SYSTEM   = 4'hF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] channel;
        logic [VAL_W-1:0]  first_value;
        logic [VAL_W-1:0]  second_value;
        logic [WIDE_W-1:0] wide_value;
    } result_t;

    typedef struct packed {
        logic    hit;
        result_t res;
    } decode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DUMP_RD,
        ST_DUMP_EMIT,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        SEL_RT,
        SEL_SYSEX,
        SEL_DECODE
    } res_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     idx_step;
        logic     sx_start;
        logic     sx_store;
        logic     sx_end;
        logic     dump_rd;
        logic     dump_step;
        logic     emit;
        res_sel_t sel;
        logic     flush;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cur_zero;
        logic cur_rt;
        logic cur_f0;
        logic cur_f7;
        logic in_sysex;
        logic scan_done;
        logic rt_en;
        logic sx_en;
        logic decode_hit;
        logic dump_last;
        logic emit_ok;
    } status_t;

    // Decodes a packet as one channel voice or system common event.
    function automatic decode_t decode_packet(input logic [VAL_W-1:0] b0,
                                              input logic [VAL_W-1:0] b1,
                                              input logic [VAL_W-1:0] b2,
                                              input logic [ENABLE_W-1:0] en);
        decode_t           d;
        logic [WIDE_W-1:0] wide;
        d = '0;
        wide = {b2, 7'b0} | {7'b0, b1};
        d.res.channel = b0[3:0];
        unique case (b0[7:4])
            ST_NOTE_ON: begin
                d.res.first_value  = b1;
                d.res.second_value = b2;
                if (b2 != '0) begin
                    d.res.kind = K_NOTE_ON;
                    d.hit = en[K_NOTE_ON];
                end else begin
                    d.res.kind = K_NOTE_OFF;
                    d.hit = en[K_NOTE_OFF];
                end
            end
            ST_NOTE_OFF: begin
                d.res.kind = K_NOTE_OFF;
                d.res.first_value  = b1;
                d.res.second_value = b2;
                d.hit = en[K_NOTE_OFF];
            end
            ST_CONTROL: begin
                d.res.kind = K_CONTROL;
                d.res.first_value  = b1;
                d.res.second_value = b2;
                d.hit = en[K_CONTROL];
            end
            ST_PROGRAM: begin
                d.res.kind = K_PROGRAM;
                d.res.first_value = b1;
                d.hit = en[K_PROGRAM];
            end
            ST_BEND: begin
                d.res.kind = K_BEND;
                d.res.wide_value = wide;
                d.hit = en[K_BEND];
            end
            ST_CHPRESS: begin
                d.res.kind = K_CHAN_PRESS;
                d.res.first_value = b1;
                d.hit = en[K_CHAN_PRESS];
            end
            ST_POLY: begin
                d.res.kind = K_POLY;
                d.res.first_value  = b1;
                d.res.second_value = b2;
                d.hit = en[K_POLY];
            end
            ST_SYSTEM: begin
                d.res.channel = '0;
                priority case (b0)
                    BYTE_MTC: begin
                        d.res.kind = K_TIMECODE;
                        d.res.first_value  = {5'b0, b1[6:4]};
                        d.res.second_value = {4'b0, b1[3:0]};
                        d.hit = en[K_TIMECODE];
                    end
                    BYTE_SPP: begin
                        d.res.kind = K_SONGPOS;
                        d.res.wide_value = wide;
                        d.hit = en[K_SONGPOS];
                    end
                    BYTE_SSEL: begin
                        d.res.kind = K_SONGSEL;
                        d.res.first_value = b1;
                        d.hit = en[K_SONGSEL];
                    end
                    BYTE_TUNE: begin
                        d.res.kind = K_TUNE;
                        d.hit = en[K_TUNE];
                    end
                    default: begin
                        d.hit = 1'b0;
                    end
                endcase
            end
            default: begin
                d.hit = 1'b0;
            end
        endcase
        return d;
    endfunction

endpackage

// ----- design/usb_midi_packet_event_parser.sv -----
// Flow: a packet is accepted in idle, its three bytes are scanned in turn, and a decoded
// event, if any, is staged; the last result of the packet then moves to the output register.
// A new packet is taken only once the last one is closed; a SysEx dump reads and emits each
// stored byte in turn and holds intake meanwhile; a full staging and output pair stalls the scan.
// Reset: synchronous, active low; clears the controller, the SysEx flag and counters, the
// staging and output valid flags, and sets every event enable bit. The SysEx store is not cleared.
module usb_midi_packet_event_parser #(
    parameter int SYSEX_BYTES = upmep_pkg::SYSEX_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [upmep_pkg::VAL_W-1:0]      s_status_byte,
    input  logic [upmep_pkg::VAL_W-1:0]      s_first_data,
    input  logic [upmep_pkg::VAL_W-1:0]      s_second_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [upmep_pkg::ENABLE_W-1:0]   cfg_event_enable,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [upmep_pkg::KIND_W-1:0]     m_event_kind,
    output logic [upmep_pkg::CHAN_W-1:0]     m_channel,
    output logic [upmep_pkg::VAL_W-1:0]      m_first_value,
    output logic [upmep_pkg::VAL_W-1:0]      m_second_value,
    output logic [upmep_pkg::WIDE_W-1:0]     m_wide_value,
    output logic                             m_last
);

    import upmep_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The enable register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    upmep_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    upmep_dp #(
        .SYSEX_BYTES (SYSEX_BYTES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_status_byte    (s_status_byte),
        .s_first_data     (s_first_data),
        .s_second_data    (s_second_data),
        .cfg_valid        (cfg_valid),
        .cfg_event_enable (cfg_event_enable),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_event_kind     (m_event_kind),
        .m_channel        (m_channel),
        .m_first_value    (m_first_value),
        .m_second_value   (m_second_value),
        .m_wide_value     (m_wide_value),
        .m_last           (m_last),
        .cmd              (cmd),
        .status           (status)
    );

endmodule

// ----- design/upmep_ram.sv -----
module upmep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/upmep_ctrl.sv -----
module upmep_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  upmep_pkg::status_t  status,
    output upmep_pkg::cmd_t     cmd
);

    import upmep_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.sel = SEL_RT;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                priority if (status.scan_done) begin
                    // All three bytes seen: decode the packet, or close it.
                    if (status.decode_hit) begin
                        if (status.emit_ok) begin
                            cmd.emit = 1'b1;
                            cmd.sel = SEL_DECODE;
                            state_next = ST_FLUSH;
                        end
                    end else if (status.emit_ok) begin
                        cmd.flush = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (status.cur_zero) begin
                    cmd.idx_step = 1'b1;
                end else if (status.cur_rt) begin
                    if (!status.rt_en) begin
                        cmd.idx_step = 1'b1;
                    end else if (status.emit_ok) begin
                        cmd.emit = 1'b1;
                        cmd.sel = SEL_RT;
                        cmd.idx_step = 1'b1;
                    end
                end else if (status.in_sysex) begin
                    cmd.sx_store = 1'b1;
                    cmd.idx_step = 1'b1;
                    if (status.cur_f7) begin
                        cmd.sx_end = 1'b1;
                        if (status.sx_en) begin
                            state_next = ST_DUMP_RD;
                        end
                    end
                end else if (status.cur_f0) begin
                    cmd.sx_start = 1'b1;
                    cmd.idx_step = 1'b1;
                end else begin
                    cmd.idx_step = 1'b1;
                end
            end
            ST_DUMP_RD: begin
                cmd.dump_rd = 1'b1;
                state_next = ST_DUMP_EMIT;
            end
            ST_DUMP_EMIT: begin
                if (status.emit_ok) begin
                    cmd.emit = 1'b1;
                    cmd.sel = SEL_SYSEX;
                    if (status.dump_last) begin
                        state_next = ST_SCAN;
                    end else begin
                        cmd.dump_step = 1'b1;
                        state_next = ST_DUMP_RD;
                    end
                end
            end
            ST_FLUSH: begin
                if (status.emit_ok) begin
                    cmd.flush = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/upmep_dp.sv -----
module upmep_dp #(
    parameter int SYSEX_BYTES = upmep_pkg::SYSEX_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [upmep_pkg::VAL_W-1:0]      s_status_byte,
    input  logic [upmep_pkg::VAL_W-1:0]      s_first_data,
    input  logic [upmep_pkg::VAL_W-1:0]      s_second_data,
    input  logic                             cfg_valid,
    input  logic [upmep_pkg::ENABLE_W-1:0]   cfg_event_enable,
    input  logic                             m_ready,
    output logic                             m_valid,
    output logic [upmep_pkg::KIND_W-1:0]     m_event_kind,
    output logic [upmep_pkg::CHAN_W-1:0]     m_channel,
    output logic [upmep_pkg::VAL_W-1:0]      m_first_value,
    output logic [upmep_pkg::VAL_W-1:0]      m_second_value,
    output logic [upmep_pkg::WIDE_W-1:0]     m_wide_value,
    output logic                             m_last,
    input  upmep_pkg::cmd_t                  cmd,
    output upmep_pkg::status_t               status
);

    import upmep_pkg::*;

    localparam int AW    = $clog2(SYSEX_BYTES);
    localparam int CNT_W = $clog2(SYSEX_BYTES + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(SYSEX_BYTES);

    // Packet bytes and scan position.
    logic [VAL_W-1:0]    b0_reg, b1_reg, b2_reg;
    logic [1:0]          idx_reg, idx_next;
    logic                touched_reg, touched_next;
    // SysEx collection state.
    logic                in_sysex_reg, in_sysex_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    dump_len_reg, dump_len_next;
    logic [AW-1:0]       dump_idx_reg, dump_idx_next;
    logic [ENABLE_W-1:0] enable_reg, enable_next;
    // Staging register and output register.
    logic                pend_valid_reg, pend_valid_next;
    result_t             pend_reg, pend_next;
    logic                m_valid_reg, m_valid_next;
    result_t             m_res_reg, m_res_next;
    logic                m_last_reg, m_last_next;

    logic [VAL_W-1:0]    cur_byte;
    logic                count_lt;
    logic [CNT_W-1:0]    count_inc;
    logic                store_wr_en;
    logic [AW-1:0]       store_wr_addr;
    logic [VAL_W-1:0]    store_q;
    decode_t             dec;
    result_t             new_res;
    logic                out_free;

    // Byte under the scan pointer; position three means the scan is over.
    always_comb begin
        unique case (idx_reg)
            2'd0:    cur_byte = b0_reg;
            2'd1:    cur_byte = b1_reg;
            2'd2:    cur_byte = b2_reg;
            default: cur_byte = '0;
        endcase
    end

    // SysEx store.
    assign count_lt      = count_reg < CAP;
    assign count_inc     = count_reg + (count_lt ? CNT_W'(1) : CNT_W'(0));
    assign store_wr_en   = cmd.sx_start || (cmd.sx_store && count_lt);
    assign store_wr_addr = cmd.sx_start ? AW'(0) : count_reg[AW-1:0];

    upmep_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SYSEX_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_wr_en),
        .wr_addr (store_wr_addr),
        .wr_data (cur_byte),
        .rd_en   (cmd.dump_rd),
        .rd_addr (dump_idx_reg),
        .rd_data (store_q)
    );

    // Event decode of the whole packet.
    assign dec = decode_packet(b0_reg, b1_reg, b2_reg, enable_reg);

    // Result selected for a new transaction.
    always_comb begin
        new_res = '0;
        unique case (cmd.sel)
            SEL_RT: begin
                new_res.kind = K_REALTIME;
                new_res.first_value = cur_byte;
            end
            SEL_SYSEX: begin
                new_res.kind = K_SYSEX;
                new_res.first_value = store_q;
                new_res.wide_value = WIDE_W'(dump_len_reg);
            end
            SEL_DECODE: begin
                new_res = dec.res;
            end
            default: begin
                new_res = '0;
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;

    // Next state of the scan and SysEx registers.
    always_comb begin
        idx_next      = idx_reg;
        touched_next  = touched_reg;
        in_sysex_next = in_sysex_reg;
        count_next    = count_reg;
        dump_len_next = dump_len_reg;
        dump_idx_next = dump_idx_reg;
        enable_next   = enable_reg;
        if (cmd.load) begin
            idx_next = '0;
            touched_next = 1'b0;
        end
        if (cmd.idx_step) begin
            idx_next = idx_reg + 2'd1;
        end
        if (cmd.sx_start) begin
            in_sysex_next = 1'b1;
            count_next = CNT_W'(1);
            touched_next = 1'b1;
        end
        if (cmd.sx_store) begin
            count_next = count_inc;
            touched_next = 1'b1;
        end
        if (cmd.sx_end) begin
            in_sysex_next = 1'b0;
            count_next = '0;
            dump_len_next = count_inc;
            dump_idx_next = '0;
        end
        if (cmd.dump_step) begin
            dump_idx_next = dump_idx_reg + AW'(1);
        end
        if (cfg_valid) begin
            enable_next = cfg_event_enable;
        end
    end

    // One result waits in staging until the next one or the packet end shows
    // whether it is the last of its packet.
    always_comb begin
        m_valid_next    = m_valid_reg && !m_ready;
        m_res_next      = m_res_reg;
        m_last_next     = m_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (cmd.emit) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_res_next = pend_reg;
                m_last_next = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next = new_res;
        end else if (cmd.flush && pend_valid_reg) begin
            m_valid_next = 1'b1;
            m_res_next = pend_reg;
            m_last_next = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            touched_reg    <= 1'b0;
            in_sysex_reg   <= 1'b0;
            count_reg      <= '0;
            dump_idx_reg   <= '0;
            enable_reg     <= ENABLE_RESET;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            idx_reg        <= idx_next;
            touched_reg    <= touched_next;
            in_sysex_reg   <= in_sysex_next;
            count_reg      <= count_next;
            dump_idx_reg   <= dump_idx_next;
            enable_reg     <= enable_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            b0_reg <= s_status_byte;
            b1_reg <= s_first_data;
            b2_reg <= s_second_data;
        end
        dump_len_reg <= dump_len_next;
        pend_reg     <= pend_next;
        m_res_reg    <= m_res_next;
        m_last_reg   <= m_last_next;
    end

    // Status toward the controller.
    always_comb begin
        status.cur_zero   = cur_byte == '0;
        status.cur_rt     = cur_byte >= BYTE_RT_MIN;
        status.cur_f0     = cur_byte == BYTE_SX_START;
        status.cur_f7     = cur_byte == BYTE_SX_END;
        status.in_sysex   = in_sysex_reg;
        status.scan_done  = idx_reg == 2'd3;
        status.rt_en      = enable_reg[K_REALTIME];
        status.sx_en      = enable_reg[K_SYSEX];
        status.decode_hit = dec.hit && !touched_reg && !in_sysex_reg;
        status.dump_last  = (CNT_W'(dump_idx_reg) + CNT_W'(1)) == dump_len_reg;
        status.emit_ok    = !pend_valid_reg || out_free;
    end

    assign m_valid        = m_valid_reg;
    assign m_event_kind   = m_res_reg.kind;
    assign m_channel      = m_res_reg.channel;
    assign m_first_value  = m_res_reg.first_value;
    assign m_second_value = m_res_reg.second_value;
    assign m_wide_value   = m_res_reg.wide_value;
    assign m_last         = m_last_reg;

endmodule

// ----- design/upmep_checker.sv -----
`include "assert_macros.svh"

module upmep_checker #(
    parameter int SYSEX_BYTES = upmep_pkg::SYSEX_BYTES_DEF
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [upmep_pkg::KIND_W-1:0]     m_event_kind,
    input logic [upmep_pkg::CHAN_W-1:0]     m_channel,
    input logic [upmep_pkg::VAL_W-1:0]      m_first_value,
    input logic [upmep_pkg::VAL_W-1:0]      m_second_value,
    input logic [upmep_pkg::WIDE_W-1:0]     m_wide_value,
    input logic                             m_last
);

    import upmep_pkg::*;

    // Reset empties the output register.
    `UPMEP_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_valid, "output valid after reset")

    // A stalled result transaction holds its payload.
    `UPMEP_ASSERT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind) && $stable(m_channel)
            && $stable(m_first_value) && $stable(m_second_value)
            && $stable(m_wide_value) && $stable(m_last),
        "stalled result changed")

    // One packet at a time: intake closes right after a transaction.
    `UPMEP_ASSERT(a_one_packet, aclk, aresetn, s_valid && s_ready |=> !s_ready, "second packet taken while busy")

    // SysEx runs carry a length between one and the store capacity.
    `UPMEP_ASSERT(a_sysex_len, aclk, aresetn,
        m_valid && (m_event_kind == K_SYSEX)
            |-> (m_wide_value != '0) && (m_wide_value <= WIDE_W'(SYSEX_BYTES)),
        "bad SysEx run length")

    // System kinds carry no channel.
    `UPMEP_ASSERT(a_sys_chan, aclk, aresetn,
        m_valid && (m_event_kind >= K_TIMECODE) |-> m_channel == '0,
        "channel set on a system result")

endmodule

bind usb_midi_packet_event_parser upmep_checker #(
    .SYSEX_BYTES (SYSEX_BYTES)
) u_upmep_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_event_kind   (m_event_kind),
    .m_channel      (m_channel),
    .m_first_value  (m_first_value),
    .m_second_value (m_second_value),
    .m_wide_value   (m_wide_value),
    .m_last         (m_last)
);

// ----- tb/sv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import upmep_pkg::*;

    localparam int SYSEX_CAP    = SYSEX_BYTES_DEF;
    // Drain margin for a full SysEx dump, which reads and emits each stored byte, plus the scan.
    localparam int DRAIN_CYCLES = 2 * SYSEX_CAP + 40;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DIR_ROWS     = 29;

    // Status bytes with no meaning outside SysEx, and one real-time byte.
    localparam logic [VAL_W-1:0] UNDEF_F4 = 8'hF4;
    localparam logic [VAL_W-1:0] UNDEF_F5 = 8'hF5;
    localparam logic [VAL_W-1:0] RT_SENSE = 8'hFE;

    typedef struct packed {
        result_t res;
        logic    last;
    } midi_event_t;

    // One row of the directed table. Where typed is set, the row carries its
    // own expectation (has_event says whether one event is due at all).
    typedef struct packed {
        logic [VAL_W-1:0] b0;
        logic [VAL_W-1:0] b1;
        logic [VAL_W-1:0] b2;
        logic             typed;
        logic             has_event;
        result_t          ev;
    } stim_row_t;

    localparam result_t NO_EVENT = '0;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [VAL_W-1:0]    s_status_byte = '0;
    logic [VAL_W-1:0]    s_first_data  = '0;
    logic [VAL_W-1:0]    s_second_data = '0;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [ENABLE_W-1:0] cfg_event_enable = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [KIND_W-1:0]   m_event_kind;
    logic [CHAN_W-1:0]   m_channel;
    logic [VAL_W-1:0]    m_first_value;
    logic [VAL_W-1:0]    m_second_value;
    logic [WIDE_W-1:0]   m_wide_value;
    logic                m_last;

    // Predictor state: enable mask and the open SysEx run.
    logic [ENABLE_W-1:0] enable_mask = '1;
    logic                sx_open     = 1'b0;
    int                  sx_len      = 0;
    logic [VAL_W-1:0]    sx_buf [SYSEX_CAP];

    midi_event_t packet_events [$];
    midi_event_t pending_events [$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    stim_row_t dir_table [DIR_ROWS];

    usb_midi_packet_event_parser u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_status_byte    (s_status_byte),
        .s_first_data     (s_first_data),
        .s_second_data    (s_second_data),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_event_enable (cfg_event_enable),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_channel        (m_channel),
        .m_first_value    (m_first_value),
        .m_second_value   (m_second_value),
        .m_wide_value     (m_wide_value),
        .m_last           (m_last)
    );

    always #1 aclk = ~aclk;

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("ERROR: timeout with %0d events still due", pending_events.size());
            $display("usb_midi_packet_event_parser: mismatch");
            $finish;
        end
    end

    function automatic string fmt_event(input midi_event_t e);
        return $sformatf("kind=%0d ch=%0d v1=%02h v2=%02h wide=%04h last=%0d",
                         e.res.kind, e.res.channel, e.res.first_value,
                         e.res.second_value, e.res.wide_value, e.last);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic void add_event(input logic [KIND_W-1:0] kind,
                                      input logic [CHAN_W-1:0] chan,
                                      input logic [VAL_W-1:0]  v1,
                                      input logic [VAL_W-1:0]  v2,
                                      input logic [WIDE_W-1:0] wide);
        midi_event_t e;
        e.res.kind         = kind;
        e.res.channel      = chan;
        e.res.first_value  = v1;
        e.res.second_value = v2;
        e.res.wide_value   = wide;
        e.last             = 1'b0;
        packet_events.push_back(e);
    endfunction

    // Works out the events of one packet into packet_events and advances the
    // SysEx state and store.
    function automatic void predict_packet(input logic [VAL_W-1:0] b0,
                                           input logic [VAL_W-1:0] b1,
                                           input logic [VAL_W-1:0] b2);
        logic [VAL_W-1:0]  pb [3];
        logic [VAL_W-1:0]  c;
        logic [CHAN_W-1:0] chan;
        logic [WIDE_W-1:0] wide;
        logic              touched;
        midi_event_t       tail;
        packet_events.delete();
        pb[0]   = b0;
        pb[1]   = b1;
        pb[2]   = b2;
        touched = 1'b0;

        // Byte scan: real-time bytes go out at once, SysEx bytes are stored.
        for (int i = 0; i < 3; i++) begin
            c = pb[i];
            if (c == '0)
                continue;
            if (c >= BYTE_RT_MIN) begin
                if (enable_mask[K_REALTIME])
                    add_event(K_REALTIME, '0, c, '0, '0);
                continue;
            end
            if (sx_open) begin
                if (sx_len < SYSEX_CAP) begin
                    sx_buf[sx_len] = c;
                    sx_len++;
                end
                if (c == BYTE_SX_END) begin
                    if (enable_mask[K_SYSEX])
                        for (int k = 0; k < sx_len; k++)
                            add_event(K_SYSEX, '0, sx_buf[k], '0, WIDE_W'(sx_len));
                    sx_len  = 0;
                    sx_open = 1'b0;
                end
                touched = 1'b1;
                continue;
            end
            if (c == BYTE_SX_START) begin
                sx_open   = 1'b1;
                sx_buf[0] = c;
                sx_len    = 1;
                touched   = 1'b1;
            end
        end

        // Channel voice and system common decode of the whole packet.
        if (!touched && !sx_open && b0 < BYTE_RT_MIN) begin
            chan = b0[3:0];
            wide = WIDE_W'((int'(b2) << 7) | int'(b1));
            case (b0[7:4])
                ST_NOTE_ON: begin
                    if (b2 != '0) begin
                        if (enable_mask[K_NOTE_ON])
                            add_event(K_NOTE_ON, chan, b1, b2, '0);
                    end else if (enable_mask[K_NOTE_OFF]) begin
                        add_event(K_NOTE_OFF, chan, b1, b2, '0);
                    end
                end
                ST_NOTE_OFF: if (enable_mask[K_NOTE_OFF])
                    add_event(K_NOTE_OFF, chan, b1, b2, '0);
                ST_CONTROL: if (enable_mask[K_CONTROL])
                    add_event(K_CONTROL, chan, b1, b2, '0);
                ST_PROGRAM: if (enable_mask[K_PROGRAM])
                    add_event(K_PROGRAM, chan, b1, '0, '0);
                ST_BEND: if (enable_mask[K_BEND])
                    add_event(K_BEND, chan, '0, '0, wide);
                ST_CHPRESS: if (enable_mask[K_CHAN_PRESS])
                    add_event(K_CHAN_PRESS, chan, b1, '0, '0);
                ST_POLY: if (enable_mask[K_POLY])
                    add_event(K_POLY, chan, b1, b2, '0);
                ST_SYSTEM: begin
                    case (b0)
                        BYTE_MTC: if (enable_mask[K_TIMECODE])
                            add_event(K_TIMECODE, '0, {5'd0, b1[6:4]}, {4'd0, b1[3:0]}, '0);
                        BYTE_SPP: if (enable_mask[K_SONGPOS])
                            add_event(K_SONGPOS, '0, '0, '0, wide);
                        BYTE_SSEL: if (enable_mask[K_SONGSEL])
                            add_event(K_SONGSEL, '0, b1, '0, '0);
                        BYTE_TUNE: if (enable_mask[K_TUNE])
                            add_event(K_TUNE, '0, '0, '0, '0);
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        // The final event of the packet carries the last flag.
        if (packet_events.size() > 0) begin
            tail      = packet_events.pop_back();
            tail.last = 1'b1;
            packet_events.push_back(tail);
        end
    endfunction

    // Offers one packet after a random gap and waits for the transaction.
    task automatic send_packet(input logic [VAL_W-1:0] b0,
                               input logic [VAL_W-1:0] b1,
                               input logic [VAL_W-1:0] b2);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_status_byte <= b0;
        s_first_data  <= b1;
        s_second_data <= b2;
        do @(posedge aclk); while (!s_ready);
        predict_packet(b0, b1, b2);
    endtask

    task automatic send_checked(input logic [VAL_W-1:0] b0,
                                input logic [VAL_W-1:0] b1,
                                input logic [VAL_W-1:0] b2);
        send_packet(b0, b1, b2);
        foreach (packet_events[i])
            pending_events.push_back(packet_events[i]);
    endtask

    task automatic write_enable(input logic [ENABLE_W-1:0] mask);
        cfg_valid        <= 1'b1;
        cfg_event_enable <= mask;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        enable_mask = mask;
    endtask

    // Waits until every due event has come out, then lets the block go quiet.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [VAL_W-1:0] rand_data();
        if ($urandom_range(3) == 0)
            return VAL_W'($urandom_range(255));
        return VAL_W'($urandom_range(127));
    endfunction

    // Body byte of a SysEx run: mostly data, sometimes zero or real-time.
    function automatic logic [VAL_W-1:0] sysex_filler();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 14)
            return VAL_W'($urandom_range(int'(BYTE_RT_MIN), 255));
        return VAL_W'($urandom_range(1, 127));
    endfunction

    // A SysEx run: start packet, body packets, and usually a terminator.
    task automatic send_sysex_run(output int sent);
        int               body_pkts;
        int               end_pos;
        logic [VAL_W-1:0] tail [3];
        body_pkts = ($urandom_range(7) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 4);
        send_checked(BYTE_SX_START, sysex_filler(), sysex_filler());
        repeat (body_pkts)
            send_checked(sysex_filler(), sysex_filler(), sysex_filler());
        sent = body_pkts + 1;
        // Now and then the run stays open, so later traffic falls into it.
        if ($urandom_range(9) != 0) begin
            end_pos = $urandom_range(2);
            for (int i = 0; i < 3; i++) begin
                if (i == end_pos)
                    tail[i] = BYTE_SX_END;
                else if (i < end_pos)
                    tail[i] = sysex_filler();
                else
                    tail[i] = VAL_W'($urandom_range(255));
            end
            send_checked(tail[0], tail[1], tail[2]);
            sent++;
        end
    endtask

    task automatic send_random_item(output int sent);
        int               r;
        logic [VAL_W-1:0] b0;
        logic [VAL_W-1:0] b1;
        logic [VAL_W-1:0] b2;
        logic [VAL_W-1:0] sys_codes [7];
        sys_codes = '{BYTE_MTC, BYTE_SPP, BYTE_SSEL, BYTE_TUNE, UNDEF_F4, UNDEF_F5,
                      BYTE_SX_END};
        r    = $urandom_range(99);
        sent = 1;
        if (r < 40) begin
            // Channel voice message, velocity zero now and then.
            b0 = {4'($urandom_range(int'(ST_NOTE_OFF), int'(ST_BEND))), 4'($urandom_range(15))};
            b1 = rand_data();
            b2 = ($urandom_range(5) == 0) ? '0 : rand_data();
            send_checked(b0, b1, b2);
        end else if (r < 50) begin
            send_checked(sys_codes[$urandom_range(6)], rand_data(), rand_data());
        end else if (r < 80) begin
            send_sysex_run(sent);
        end else begin
            // Noise, with zero and real-time bytes mixed in.
            b0 = ($urandom_range(3) == 0) ? sysex_filler() : VAL_W'($urandom_range(255));
            b1 = ($urandom_range(3) == 0) ? sysex_filler() : VAL_W'($urandom_range(255));
            b2 = ($urandom_range(3) == 0) ? sysex_filler() : VAL_W'($urandom_range(255));
            send_checked(b0, b1, b2);
        end
    endtask

    task automatic run_random(input int items);
        int done;
        int sent;
        done = 0;
        while (done < items) begin
            send_random_item(sent);
            done += sent;
        end
    endtask

    // Result side: checks each transaction and drives ready.
    initial begin : result_side
        midi_event_t got;
        midi_event_t want;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.res.kind         = m_event_kind;
                got.res.channel      = m_channel;
                got.res.first_value  = m_first_value;
                got.res.second_value = m_second_value;
                got.res.wide_value   = m_wide_value;
                got.last             = m_last;
                if (pending_events.size() == 0) begin
                    report_mismatch({"unexpected event ", fmt_event(got)});
                end else begin
                    want = pending_events.pop_front();
                    if (got !== want)
                        report_mismatch({"got ", fmt_event(got), " want ", fmt_event(want)});
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Stimulus: directed table, then random phases under several enable masks.
    initial begin : stimulus
        dir_table = '{
            '{{ST_NOTE_ON, 4'h0}, 8'h3C, 8'h40, 1'b1, 1'b1,
              '{K_NOTE_ON, 4'h0, 8'h3C, 8'h40, 15'h0}},
            '{{ST_NOTE_ON, 4'hF}, 8'h7F, 8'h00, 1'b1, 1'b1,
              '{K_NOTE_OFF, 4'hF, 8'h7F, 8'h00, 15'h0}},
            '{{ST_NOTE_OFF, 4'h0}, 8'h00, 8'h00, 1'b1, 1'b1,
              '{K_NOTE_OFF, 4'h0, 8'h00, 8'h00, 15'h0}},
            '{{ST_CONTROL, 4'hF}, 8'h7F, 8'h7F, 1'b1, 1'b1,
              '{K_CONTROL, 4'hF, 8'h7F, 8'h7F, 15'h0}},
            '{{ST_PROGRAM, 4'h5}, 8'h12, 8'h34, 1'b1, 1'b1,
              '{K_PROGRAM, 4'h5, 8'h12, 8'h00, 15'h0}},
            '{{ST_BEND, 4'h3}, 8'h7F, 8'h7F, 1'b1, 1'b1,
              '{K_BEND, 4'h3, 8'h00, 8'h00, 15'h3FFF}},
            '{{ST_CHPRESS, 4'h2}, 8'h55, 8'hAA, 1'b1, 1'b1,
              '{K_CHAN_PRESS, 4'h2, 8'h55, 8'h00, 15'h0}},
            '{{ST_POLY, 4'h7}, 8'h40, 8'h20, 1'b1, 1'b1,
              '{K_POLY, 4'h7, 8'h40, 8'h20, 15'h0}},
            '{BYTE_MTC, 8'h5A, 8'h00, 1'b1, 1'b1,
              '{K_TIMECODE, 4'h0, 8'h05, 8'h0A, 15'h0}},
            '{BYTE_SPP, 8'h7F, 8'h7F, 1'b1, 1'b1,
              '{K_SONGPOS, 4'h0, 8'h00, 8'h00, 15'h3FFF}},
            '{BYTE_SSEL, 8'h09, 8'h00, 1'b1, 1'b1,
              '{K_SONGSEL, 4'h0, 8'h09, 8'h00, 15'h0}},
            '{BYTE_TUNE, 8'h00, 8'h00, 1'b1, 1'b1,
              '{K_TUNE, 4'h0, 8'h00, 8'h00, 15'h0}},
            '{UNDEF_F4, 8'h00, 8'h00, 1'b1, 1'b0, NO_EVENT},
            '{BYTE_SX_END, 8'h11, 8'h22, 1'b1, 1'b0, NO_EVENT},
            '{8'h45, 8'h10, 8'h20, 1'b1, 1'b0, NO_EVENT},
            '{BYTE_RT_MIN, {ST_NOTE_ON, 4'h0}, 8'h40, 1'b1, 1'b1,
              '{K_REALTIME, 4'h0, BYTE_RT_MIN, 8'h00, 15'h0}},
            // Real-time byte in the middle, then the note is still decoded.
            '{{ST_NOTE_ON, 4'h0}, 8'hFF, 8'h3C, 1'b0, 1'b0, NO_EVENT},
            // SysEx run that overflows the store; zero and real-time inside.
            '{BYTE_SX_START, 8'h11, 8'h22, 1'b0, 1'b0, NO_EVENT},
            '{RT_SENSE, 8'h33, 8'h00, 1'b0, 1'b0, NO_EVENT},
            '{8'h7F, 8'h80, 8'h01, 1'b0, 1'b0, NO_EVENT},
            '{8'h10, 8'h20, 8'h30, 1'b0, 1'b0, NO_EVENT},
            '{8'h40, 8'h50, 8'h60, 1'b0, 1'b0, NO_EVENT},
            '{8'h70, 8'h8F, 8'h9F, 1'b0, 1'b0, NO_EVENT},
            '{8'hAF, 8'hBF, 8'hCF, 1'b0, 1'b0, NO_EVENT},
            '{8'hDF, 8'hEF, 8'hF1, 1'b0, 1'b0, NO_EVENT},
            '{8'hF2, 8'hF3, 8'hF4, 1'b0, 1'b0, NO_EVENT},
            '{8'hF5, 8'hF6, 8'h02, 1'b0, 1'b0, NO_EVENT},
            '{8'h03, 8'h04, 8'h05, 1'b0, 1'b0, NO_EVENT},
            // The store fills on the first byte here; the terminator is dropped but still ends the run.
            '{8'h44, 8'h55, BYTE_SX_END, 1'b0, 1'b0, NO_EVENT}
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 31;
        recv_idle_pct = 81;
        write_enable('1);
        foreach (dir_table[i]) begin
            send_packet(dir_table[i].b0, dir_table[i].b1, dir_table[i].b2);
            if (!dir_table[i].typed) begin
                foreach (packet_events[j])
                    pending_events.push_back(packet_events[j]);
            end else if (dir_table[i].has_event) begin
                pending_events.push_back(midi_event_t'{dir_table[i].ev, 1'b1});
            end
        end

        settle();
        write_enable(ENABLE_W'($urandom_range(8191)));
        run_random(110);

        // Every kind masked off: nothing may come out.
        settle();
        write_enable('0);
        run_random(20);

        send_idle_pct = 81;
        recv_idle_pct = 31;
        settle();
        write_enable('1);
        run_random(100);

        // Full rate, with a long receiver hold-off so the block backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle();
        write_enable('1);
        hold_left = HOLD_CYCLES;
        run_random(60);

        settle();
        write_enable(ENABLE_W'($urandom_range(8191)));
        run_random(60);

        settle();
        if (mismatch_count == 0) begin
            $display("usb_midi_packet_event_parser: match");
        end else begin
            $display("usb_midi_packet_event_parser: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/upmep_pkg.sv
design/upmep_ram.sv
design/upmep_ctrl.sv
design/upmep_dp.sv
design/usb_midi_packet_event_parser.sv
design/upmep_checker.sv
tb/sv/tb_top.sv
